/* sv/i2cm_pkg.sv */
package i2cm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int TICK_W        = 16;
    localparam int BIT_CNT_W     = 4;
    localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd7;

    typedef enum logic [2:0] {
        MODE_NONE      = 3'd0,
        MODE_START     = 3'd1,
        MODE_STOP      = 3'd2,
        MODE_WRITE     = 3'd3,
        MODE_READ_ACK  = 3'd4,
        MODE_READ_NACK = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BUS_BUSY  = 2'd1,
        ST_NO_START  = 2'd2,
        ST_NACK      = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        PH_IDLE        = 5'd0,
        PH_ST_HIGH     = 5'd1,
        PH_ST_LOW      = 5'd2,
        PH_ST_CLK      = 5'd3,
        PH_SP_0        = 5'd4,
        PH_SP_1        = 5'd5,
        PH_SP_2        = 5'd6,
        PH_SP_3        = 5'd7,
        PH_WB_CLK_LOW  = 5'd8,
        PH_WB_DATA     = 5'd9,
        PH_WB_CLK_HIGH = 5'd10,
        PH_WA_CLK_LOW  = 5'd11,
        PH_WA_REL      = 5'd12,
        PH_WA_CLK_HIGH = 5'd13,
        PH_WA_END      = 5'd14,
        PH_RB_CLK_LOW  = 5'd15,
        PH_RB_CLK_HIGH = 5'd16,
        PH_RA_CLK_LOW  = 5'd17,
        PH_RA_DATA     = 5'd18,
        PH_RA_CLK_HIGH = 5'd19,
        PH_RA_END      = 5'd20
    } phase_t;

    // result word, scl_out in the lowest bit
    typedef struct packed {
        status_t    status;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } res_t;

    localparam int RES_W = $bits(res_t);

endpackage

/* sv/i2cm_core.sv */
module i2cm_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [i2cm_pkg::TICK_W-1:0] cfg_wdata,
    input  logic                        accept,
    input  logic [2:0]                  mode,
    input  logic [7:0]                  data_byte,
    input  logic                        sda_in,
    output i2cm_pkg::res_t              result
);
    import i2cm_pkg::*;

    logic [TICK_W-1:0]    phase_ticks_reg;
    phase_t               phase_reg, phase_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [BIT_CNT_W-1:0] bit_reg, bit_next;
    logic [7:0]           shift_reg, shift_next;
    mode_t                cmd_reg, cmd_next;
    status_t              status_reg, status_next;
    logic [7:0]           rx_reg, rx_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;

    logic [TICK_W-1:0]    limit;
    logic [TICK_W-1:0]    tick_inc;
    logic [BIT_CNT_W-1:0] bit_inc;
    logic                 phase_end;
    logic                 start_cmd;
    logic                 enter;
    phase_t               enter_ph;
    logic                 fin;
    status_t              fin_status;
    logic                 ack_sample;
    logic                 rd_sample;
    logic [7:0]           shift_base;

    assign limit     = (phase_ticks_reg == '0) ? TICK_W'(1) : phase_ticks_reg;
    assign tick_inc  = tick_reg + TICK_W'(1);
    assign bit_inc   = bit_reg + BIT_CNT_W'(1);
    assign phase_end = (phase_reg != PH_IDLE) && (tick_inc >= limit);

    // phase sequencing
    always_comb
    begin
        start_cmd  = 1'b0;
        enter      = 1'b0;
        enter_ph   = PH_IDLE;
        fin        = 1'b0;
        fin_status = ST_OK;
        ack_sample = 1'b0;
        rd_sample  = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            case (mode_t'(mode))
                MODE_START:     begin start_cmd = 1'b1; enter = 1'b1; enter_ph = PH_ST_HIGH;    end
                MODE_STOP:      begin start_cmd = 1'b1; enter = 1'b1; enter_ph = PH_SP_0;       end
                MODE_WRITE:     begin start_cmd = 1'b1; enter = 1'b1; enter_ph = PH_WB_CLK_LOW; end
                MODE_READ_ACK,
                MODE_READ_NACK: begin start_cmd = 1'b1; enter = 1'b1; enter_ph = PH_RB_CLK_LOW; end
                default:        start_cmd = 1'b0;
            endcase
        end
        else if (phase_end)
        begin
            case (phase_reg)
                PH_ST_HIGH:
                    if (!sda_in) begin fin = 1'b1; fin_status = ST_BUS_BUSY; end
                    else         begin enter = 1'b1; enter_ph = PH_ST_LOW; end
                PH_ST_LOW:
                    if (sda_in)  begin fin = 1'b1; fin_status = ST_NO_START; end
                    else         begin enter = 1'b1; enter_ph = PH_ST_CLK; end
                PH_SP_0:        begin enter = 1'b1; enter_ph = PH_SP_1;        end
                PH_SP_1:        begin enter = 1'b1; enter_ph = PH_SP_2;        end
                PH_SP_2:        begin enter = 1'b1; enter_ph = PH_SP_3;        end
                PH_WB_CLK_LOW:  begin enter = 1'b1; enter_ph = PH_WB_DATA;     end
                PH_WB_DATA:     begin enter = 1'b1; enter_ph = PH_WB_CLK_HIGH; end
                PH_WB_CLK_HIGH:
                begin
                    enter    = 1'b1;
                    enter_ph = (bit_inc >= BIT_CNT_W'(BITS_PER_BYTE)) ? PH_WA_CLK_LOW
                                                                      : PH_WB_CLK_LOW;
                end
                PH_WA_CLK_LOW:  begin enter = 1'b1; enter_ph = PH_WA_REL;      end
                PH_WA_REL:      begin enter = 1'b1; enter_ph = PH_WA_CLK_HIGH; end
                PH_WA_CLK_HIGH: begin ack_sample = 1'b1; enter = 1'b1; enter_ph = PH_WA_END; end
                PH_WA_END:      begin fin = 1'b1; fin_status = status_reg; end
                PH_RB_CLK_LOW:  begin enter = 1'b1; enter_ph = PH_RB_CLK_HIGH; end
                PH_RB_CLK_HIGH:
                begin
                    rd_sample = 1'b1;
                    enter     = 1'b1;
                    enter_ph  = (bit_inc >= BIT_CNT_W'(BITS_PER_BYTE)) ? PH_RA_CLK_LOW
                                                                       : PH_RB_CLK_LOW;
                end
                PH_RA_CLK_LOW:  begin enter = 1'b1; enter_ph = PH_RA_DATA;     end
                PH_RA_DATA:     begin enter = 1'b1; enter_ph = PH_RA_CLK_HIGH; end
                PH_RA_CLK_HIGH: begin enter = 1'b1; enter_ph = PH_RA_END;      end
                default:        begin fin = 1'b1; fin_status = ST_OK; end
            endcase
        end

        phase_next = phase_reg;
        tick_next  = tick_reg;
        if (enter)
        begin
            phase_next = enter_ph;
            tick_next  = '0;
        end
        else if (fin)
        begin
            phase_next = PH_IDLE;
            tick_next  = '0;
        end
        else if (phase_reg != PH_IDLE)
        begin
            tick_next = tick_inc;
        end
    end

    // line drives and data path
    always_comb
    begin
        cmd_next    = cmd_reg;
        status_next = status_reg;
        bit_next    = bit_reg;
        rx_next     = rx_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        shift_base  = shift_reg;

        if (start_cmd)
        begin
            cmd_next    = mode_t'(mode);
            status_next = ST_OK;
            bit_next    = '0;
            shift_base  = (mode_t'(mode) == MODE_WRITE) ? data_byte : 8'h00;
        end
        if (phase_end && (phase_reg == PH_WB_CLK_HIGH || phase_reg == PH_RB_CLK_HIGH))
            bit_next = bit_inc;
        if (rd_sample)
        begin
            shift_base = {shift_reg[6:0], sda_in};
            if (bit_inc >= BIT_CNT_W'(BITS_PER_BYTE))
                rx_next = shift_base;
        end
        if (ack_sample)
            status_next = sda_in ? ST_NACK : ST_OK;
        if (fin)
            status_next = fin_status;

        shift_next = shift_base;
        if (enter)
        begin
            case (enter_ph)
                PH_ST_HIGH:     begin sda_next = 1'b1; scl_next = 1'b1; end
                PH_ST_LOW:      sda_next = 1'b0;
                PH_ST_CLK:      scl_next = 1'b0;
                PH_SP_0:        scl_next = 1'b0;
                PH_SP_1:        sda_next = 1'b0;
                PH_SP_2:        scl_next = 1'b1;
                PH_SP_3:        sda_next = 1'b1;
                PH_WB_CLK_LOW:  scl_next = 1'b0;
                PH_WB_DATA:
                begin
                    sda_next   = shift_base[7];
                    shift_next = {shift_base[6:0], 1'b0};
                end
                PH_WB_CLK_HIGH: scl_next = 1'b1;
                PH_WA_CLK_LOW:  scl_next = 1'b0;
                PH_WA_REL:      sda_next = 1'b1;
                PH_WA_CLK_HIGH: scl_next = 1'b1;
                PH_WA_END:      scl_next = 1'b0;
                PH_RB_CLK_LOW:  begin sda_next = 1'b1; scl_next = 1'b0; end
                PH_RB_CLK_HIGH: scl_next = 1'b1;
                PH_RA_CLK_LOW:  scl_next = 1'b0;
                PH_RA_DATA:     sda_next = (cmd_reg == MODE_READ_ACK) ? 1'b0 : 1'b1;
                PH_RA_CLK_HIGH: scl_next = 1'b1;
                PH_RA_END:      scl_next = 1'b0;
                default:        scl_next = scl_reg;
            endcase
        end
    end

    always_comb
    begin
        result.scl_out  = scl_next;
        result.sda_out  = sda_next;
        result.busy_res = (phase_next != PH_IDLE);
        result.done_res = fin;
        result.rx_byte  = rx_next;
        result.status   = status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_ticks_reg <= PHASE_TICKS_RESET;
        else if (cfg_we)
            phase_ticks_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            tick_reg   <= '0;
            bit_reg    <= '0;
            shift_reg  <= '0;
            cmd_reg    <= MODE_NONE;
            status_reg <= ST_OK;
            rx_reg     <= '0;
            scl_reg    <= 1'b1;
            sda_reg    <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            cmd_reg    <= cmd_next;
            status_reg <= status_next;
            rx_reg     <= rx_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
        end
    end

endmodule

/* sv/i2cm_out_buf.sv */
module i2cm_out_buf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  i2cm_pkg::res_t push_data,
    output logic           push_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output i2cm_pkg::res_t out_data
);
    import i2cm_pkg::*;

    res_t main_reg;
    res_t skid_reg;
    logic main_valid_reg;
    logic skid_valid_reg;
    logic pop;

    assign pop        = main_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // drain the skid word into the output stage
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
                main_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
                main_reg <= push_data;
            else
                skid_reg <= push_data;
        end
    end

endmodule

/* sv/i2c_master_byte_engine.sv */
// A result word is formed combinationally from its accepted input word and registered in the output stage.
// Throughput: one input word per cycle while s_tready is high; each word is one timebase tick of the phase logic.
// A two-entry output stage holds results so input keeps flowing during a short stall.
// Reset (rst_n low, asynchronous): phase idle, both lines released, phase_ticks back to 7,
// status, received byte and output stage cleared.
module i2c_master_byte_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [i2cm_pkg::TICK_W-1:0] cfg_wdata,   // phase_ticks
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,     // mode[2:0], data_byte[10:3], sda_in[11]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata      // scl_out, sda_out, busy_res, done_res,
                                                     // rx_byte[11:4], status[13:12]
);
    import i2cm_pkg::*;

    logic accept;
    res_t core_res;
    res_t out_res;

    assign accept = s_tvalid && s_tready;

    i2cm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .mode      (s_tdata[2:0]),
        .data_byte (s_tdata[10:3]),
        .sda_in    (s_tdata[11]),
        .result    (core_res)
    );

    i2cm_out_buf u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (core_res),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_res)
    );

    assign m_tdata = {(16 - RES_W)'(0), out_res};

endmodule

/* sv/i2cm_checker.sv */
module i2cm_checker (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

    // a finishing command never reports busy in the same word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> !m_tdata[2])
    else $error("done and busy set together");

    // input only stalls while a result word is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

    // input reopens only after a result word was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_tready) |-> $past(m_tvalid && m_tready))
    else $error("input reopened without a result taken");

    // words accepted back to back reach the output without a gap while it is drained
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted word produced no result");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
